FILE: rtl/core/c2d_pkg.sv
// shared types and codes for the multichannel convolution block
package c2d_pkg;

    // operation codes of an input request
    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_PIXEL   = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } c2d_op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_KERNEL   = 3'd0;
    localparam logic [2:0] CFG_PADDING  = 3'd1;
    localparam logic [2:0] CFG_CHANNELS = 3'd2;
    localparam logic [2:0] CFG_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_FILTERS  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    // signed width for pixel positions around the padding border
    localparam int POS_W      = 10;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         filter_index;
        logic [2:0]         tap_row;
        logic [2:0]         tap_col;
        logic [1:0]         channel_index;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] value;
    } c2d_in_t;

    typedef struct packed {
        logic signed [47:0] conv_sum;
        logic               out_of_range;
    } c2d_out_t;

endpackage

FILE: rtl/core/c2d_ram.sv
// generic single write port, single read port ram with registered read
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/conv2d_multichannel_accumulate.sv
// A write request is stored in its ram as it is accepted; an out-of-range compute skips
// the tap loop and goes straight to ST_DONE, which loads its result once the output is free.
// A compute walks channels x K x K taps, one multiply-accumulate per cycle through the
// weight and image rams, then drains the pipeline before its sum is loaded.
// Throughput is set by that tap loop; one request is worked on at a time.
// Reset: synchronous active low; the weight ram is swept to zero afterward, one entry a
// cycle over all MAX_FILTERS*MAX_KERNEL*MAX_KERNEL entries, before s_ready rises.
module conv2d_multichannel_accumulate
    import c2d_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_KERNEL   = 5,
    parameter int MAX_FILTERS  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  c2d_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output c2d_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL;
    localparam int IDEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE
    } state_t;

    state_t state_reg;
    logic [WA_W-1:0] clr_cnt_reg;

    // configuration registers, raw bits
    logic [2:0] kernel_reg;
    logic [1:0] padding_reg;
    logic [2:0] channels_reg;
    logic [6:0] height_reg;
    logic [6:0] width_reg;
    logic [3:0] filters_reg;

    // request context and tap counters
    logic [2:0]  f_reg;
    logic [5:0]  orow_reg;
    logic [5:0]  ocol_reg;
    logic [3:0]  kx_reg;
    logic [3:0]  ky_reg;
    logic [2:0]  ch_reg;
    logic        oor_reg;

    // mac pipeline
    logic               v1_reg;
    logic               ok1_reg;
    logic               v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] acc_reg;

    logic               m_valid_reg;
    c2d_out_t           m_data_reg;

    // saturated configuration
    logic [3:0] k_sat;
    logic [1:0] p_sat;
    logic [2:0] nc_sat;
    logic [6:0] h_sat;
    logic [6:0] w_sat;
    logic [3:0] nf_sat;

    always_comb begin
        k_sat  = (kernel_reg == 3'd0) ? 4'd1 :
                 (int'(kernel_reg) > MAX_KERNEL) ? 4'(MAX_KERNEL) : {1'b0, kernel_reg};
        p_sat  = (padding_reg > 2'd2) ? 2'd2 : padding_reg;
        nc_sat = (channels_reg == 3'd0) ? 3'd1 :
                 (int'(channels_reg) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : channels_reg;
        h_sat  = (height_reg == 7'd0) ? 7'd1 :
                 (int'(height_reg) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_reg;
        w_sat  = (width_reg == 7'd0) ? 7'd1 :
                 (int'(width_reg) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_reg;
        nf_sat = (filters_reg == 4'd0) ? 4'd1 :
                 (int'(filters_reg) > MAX_FILTERS) ? 4'(MAX_FILTERS) : filters_reg;
    end

    // valid output area check for a new compute request, the area may be empty
    logic signed [POS_W-1:0] out_rows;
    logic signed [POS_W-1:0] out_cols;
    logic                    req_oor;

    always_comb begin
        out_rows = POS_W'(h_sat) + POS_W'({p_sat, 1'b0}) - POS_W'(k_sat) + POS_W'(1);
        out_cols = POS_W'(w_sat) + POS_W'({p_sat, 1'b0}) - POS_W'(k_sat) + POS_W'(1);
        req_oor  = ({1'b0, s_data.filter_index} >= nf_sat)
                || ($signed(POS_W'(s_data.row)) >= out_rows)
                || ($signed(POS_W'(s_data.col)) >= out_cols);
    end

    // tap position and addresses for the current issue
    logic signed [POS_W-1:0] pr;
    logic signed [POS_W-1:0] pc;
    logic                    tap_ok;
    logic                    issue;
    logic                    last_tap;
    logic [WA_W-1:0]         w_raddr;
    logic [IA_W-1:0]         i_raddr;

    always_comb begin
        pr       = POS_W'(orow_reg) + POS_W'(ky_reg) - POS_W'(p_sat);
        pc       = POS_W'(ocol_reg) + POS_W'(kx_reg) - POS_W'(p_sat);
        tap_ok   = (pr >= 0) && (pr < POS_W'(h_sat)) && (pc >= 0) && (pc < POS_W'(w_sat));
        issue    = (state_reg == ST_RUN);
        last_tap = (kx_reg == k_sat - 4'd1) && (ky_reg == k_sat - 4'd1)
                && (ch_reg == nc_sat - 3'd1);
        w_raddr  = WA_W'((int'(f_reg) * MAX_KERNEL + int'(ky_reg)) * MAX_KERNEL
                         + int'(kx_reg));
        i_raddr  = IA_W'((int'(ch_reg) * MAX_HEIGHT + int'(pr[6:0])) * MAX_WIDTH
                         + int'(pc[6:0]));
    end

    // ram write ports: clearing sweep, weight and pixel requests
    logic              s_fire;
    logic              w_we;
    logic [WA_W-1:0]   w_waddr;
    logic [15:0]       w_wdata;
    logic              i_we;
    logic [IA_W-1:0]   i_waddr;
    logic [15:0]       w_rdata;
    logic [15:0]       i_rdata;

    always_comb begin
        s_fire = s_valid && s_ready;
        if (state_reg == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = clr_cnt_reg;
            w_wdata = '0;
        end else begin
            w_we    = s_fire && (s_data.operation == OP_WEIGHT)
                   && (int'(s_data.filter_index) < MAX_FILTERS)
                   && (int'(s_data.tap_row) < MAX_KERNEL)
                   && (int'(s_data.tap_col) < MAX_KERNEL);
            w_waddr = WA_W'((int'(s_data.filter_index) * MAX_KERNEL + int'(s_data.tap_row))
                            * MAX_KERNEL + int'(s_data.tap_col));
            w_wdata = s_data.value;
        end
        i_we    = s_fire && (s_data.operation == OP_PIXEL)
               && (int'(s_data.channel_index) < MAX_CHANNELS)
               && (int'(s_data.row) < MAX_HEIGHT)
               && (int'(s_data.col) < MAX_WIDTH);
        i_waddr = IA_W'((int'(s_data.channel_index) * MAX_HEIGHT + int'(s_data.row))
                        * MAX_WIDTH + int'(s_data.col));
    end

    c2d_ram #(.WIDTH(16), .DEPTH(WDEPTH), .AW(WA_W)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    c2d_ram #(.WIDTH(16), .DEPTH(IDEPTH), .AW(IA_W)) u_image_ram (
        .aclk  (aclk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (s_data.value),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    // sequencer, mac pipeline and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            kernel_reg   <= 3'd3;
            padding_reg  <= 2'd1;
            channels_reg <= 3'd1;
            height_reg   <= 7'd64;
            width_reg    <= 7'd64;
            filters_reg  <= 4'd1;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_KERNEL:   kernel_reg   <= cfg_data[2:0];
                    CFG_PADDING:  padding_reg  <= cfg_data[1:0];
                    CFG_CHANNELS: channels_reg <= cfg_data[2:0];
                    CFG_HEIGHT:   height_reg   <= cfg_data;
                    CFG_WIDTH:    width_reg    <= cfg_data;
                    CFG_FILTERS:  filters_reg  <= cfg_data[3:0];
                    default: begin
                    end
                endcase
            end

            // result valid: a new sum replaces one taken this cycle
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // multiply then accumulate, padding taps count as zero
            v1_reg   <= issue;
            ok1_reg  <= tap_ok;
            v2_reg   <= v1_reg;
            prod_reg <= ok1_reg ? $signed(w_rdata) * $signed(i_rdata) : 32'sd0;
            if (v2_reg) begin
                acc_reg <= acc_reg + 48'(prod_reg);
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == WA_W'(WDEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_data.operation == OP_COMPUTE) begin
                        f_reg    <= s_data.filter_index;
                        orow_reg <= s_data.row;
                        ocol_reg <= s_data.col;
                        kx_reg   <= '0;
                        ky_reg   <= '0;
                        ch_reg   <= '0;
                        acc_reg  <= '0;
                        oor_reg  <= req_oor;
                        state_reg <= req_oor ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (kx_reg != k_sat - 4'd1) begin
                        kx_reg <= kx_reg + 4'd1;
                    end else begin
                        kx_reg <= '0;
                        if (ky_reg != k_sat - 4'd1) begin
                            ky_reg <= ky_reg + 4'd1;
                        end else begin
                            ky_reg <= '0;
                            ch_reg <= ch_reg + 3'd1;
                        end
                    end
                    if (last_tap) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.conv_sum     <= oor_reg ? 48'sd0 : acc_reg;
                        m_data_reg.out_of_range <= oor_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // no request is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during weight clear");

    // an out-of-range result carries a zero sum
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_range) |-> (m_data.conv_sum == 48'sd0))
        else $error("out-of-range result with nonzero sum");

    // product stage only follows a read stage
    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> $past(v1_reg))
        else $error("mac pipeline out of order");

    // result is only loaded after the pipeline has drained
    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (!v1_reg && !v2_reg))
        else $error("result loaded with taps in flight");

endmodule

FILE: bench/tb_top.sv
// testbench for the multichannel convolution block: directed table, random requests, checks
module tb_top;
    import c2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 8, NK = 5, NCH = 4, NH = 64, NW = 64;
    localparam int ITEMS = 1650;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int WRITE_SETTLE = 8;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    c2d_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    c2d_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    conv2d_multichannel_accumulate u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // mirror of the block's stores and settings
    shortint weights [NF][NK][NK];
    shortint pixels [NCH][NH][NW];
    bit pixel_written [NCH][NH][NW];
    logic [6:0] reg_raw [6];
    int k_eff, p_eff, c_eff, h_eff, w_eff, f_eff, rows_valid, cols_valid;

    c2d_out_t pending_sums[$];
    int errors = 0;
    int requests_sent = 0;
    int sums_seen = 0;
    int range_flags = 0;
    bit calm = 1'b0;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic void refresh_settings();
        k_eff = clamp(int'(reg_raw[CFG_KERNEL] & 7'd7), 1, NK);
        p_eff = clamp(int'(reg_raw[CFG_PADDING] & 7'd3), 0, 2);
        c_eff = clamp(int'(reg_raw[CFG_CHANNELS] & 7'd7), 1, NCH);
        h_eff = clamp(int'(reg_raw[CFG_HEIGHT]), 1, NH);
        w_eff = clamp(int'(reg_raw[CFG_WIDTH]), 1, NW);
        f_eff = clamp(int'(reg_raw[CFG_FILTERS] & 7'd15), 1, NF);
        rows_valid = h_eff + 2 * p_eff - k_eff + 1;
        cols_valid = w_eff + 2 * p_eff - k_eff + 1;
    endfunction

    function automatic bit outside_area(c2d_in_t q);
        return int'(q.filter_index) >= f_eff || int'(q.row) >= rows_valid
            || int'(q.col) >= cols_valid;
    endfunction

    // update the mirror with one request, return the sum it produces if any
    function automatic bit convolve(c2d_in_t q, output c2d_out_t res);
        longint acc = 0;
        int pr, pc;
        res = '0;
        case (c2d_op_t'(q.operation))
            OP_WEIGHT: begin
                if (q.tap_row < NK && q.tap_col < NK)
                    weights[q.filter_index][q.tap_row][q.tap_col] = q.value;
                return 1'b0;
            end
            OP_PIXEL: begin
                pixels[q.channel_index][q.row][q.col] = q.value;
                pixel_written[q.channel_index][q.row][q.col] = 1'b1;
                return 1'b0;
            end
            OP_COMPUTE: begin
                if (outside_area(q)) begin
                    res.out_of_range = 1'b1;
                    return 1'b1;
                end
                for (int ch = 0; ch < c_eff; ch++)
                    for (int ky = 0; ky < k_eff; ky++)
                        for (int kx = 0; kx < k_eff; kx++) begin
                            pr = int'(q.row) + ky - p_eff;
                            pc = int'(q.col) + kx - p_eff;
                            if (pr >= 0 && pr < h_eff && pc >= 0 && pc < w_eff)
                                acc += longint'(int'(weights[q.filter_index][ky][kx])
                                    * int'(pixels[ch][pr][pc]));
                        end
                res.conv_sum = acc[47:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll = $urandom_range(99);
        if (calm || roll < 60) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // one request on the input channel, expectation queued on acceptance
    task automatic send(c2d_in_t q, bit typed = 1'b0, c2d_out_t typed_sum = '0);
        int gap = pick_gap();
        c2d_out_t res;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if (convolve(q, res)) pending_sums.push_back(typed ? typed_sum : res);
    endtask

    function automatic c2d_in_t noise_request();
        c2d_in_t q;
        q = c2d_in_t'(($bits(c2d_in_t))'({$urandom, $urandom}));
        return q;
    endfunction

    // fill every unwritten pixel a compute will read
    task automatic fill_window(c2d_in_t q);
        c2d_in_t wr;
        int pr, pc;
        if (outside_area(q)) return;
        for (int ch = 0; ch < c_eff; ch++)
            for (int ky = 0; ky < k_eff; ky++)
                for (int kx = 0; kx < k_eff; kx++) begin
                    pr = int'(q.row) + ky - p_eff;
                    pc = int'(q.col) + kx - p_eff;
                    if (pr >= 0 && pr < h_eff && pc >= 0 && pc < w_eff
                            && !pixel_written[ch][pr][pc]) begin
                        wr = noise_request();
                        wr.operation = OP_PIXEL;
                        wr.channel_index = ch[1:0];
                        wr.row = pr[5:0];
                        wr.col = pc[5:0];
                        send(wr);
                    end
                end
    endtask

    task automatic compute(c2d_in_t q, bit typed = 1'b0, c2d_out_t typed_sum = '0);
        fill_window(q);
        send(q, typed, typed_sum);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_raw[idx] = data;
        refresh_settings();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (WRITE_SETTLE) @(posedge aclk);
    endtask

    function automatic c2d_in_t make(c2d_op_t op, int f, int tr, int tc, int ch,
                                     int r, int c, logic [15:0] v);
        c2d_in_t q;
        q = noise_request();
        q.operation = op;
        q.filter_index = f[2:0];
        q.tap_row = tr[2:0];
        q.tap_col = tc[2:0];
        q.channel_index = ch[1:0];
        q.row = r[5:0];
        q.col = c[5:0];
        q.value = v;
        return q;
    endfunction

    // directed rows, checked against typed sums where marked
    typedef struct {
        c2d_in_t req;
        bit typed;
        c2d_out_t sum;
    } directed_row_t;

    // settings per phase: kernel, padding, channels, height, width, filters
    typedef logic [6:0] phase_regs_t [6];
    localparam phase_regs_t PHASES [7] = '{
        '{7'd5, 7'd2, 7'd4, 7'd8, 7'd8, 7'd8},
        '{7'd1, 7'd0, 7'd1, 7'd64, 7'd64, 7'd1},
        '{7'd3, 7'd1, 7'd2, 7'd16, 7'd12, 7'd4},
        '{7'd0, 7'd3, 7'd7, 7'd0, 7'd0, 7'd0},
        '{7'd7, 7'd0, 7'd4, 7'd127, 7'd127, 7'd15},
        '{7'd4, 7'd2, 7'd3, 7'd5, 7'd7, 7'd6},
        '{7'd5, 7'd0, 7'd1, 7'd3, 7'd3, 7'd2}
    };
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
        CFG_KERNEL, CFG_PADDING, CFG_CHANNELS, CFG_HEIGHT, CFG_WIDTH, CFG_FILTERS
    };

    // result side: random stalls and checking against the oldest expectation
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (aresetn && $urandom_range(99) < 20) stall_left <= pick_gap();
        end
        if (aresetn && m_valid && m_ready) begin
            c2d_out_t want;
            if (pending_sums.size() == 0) begin
                $error("unexpected result conv_sum=%0d", m_data.conv_sum);
                errors++;
            end else begin
                want = pending_sums.pop_front();
                sums_seen++;
                if (want.out_of_range) range_flags++;
                if (m_data.conv_sum !== want.conv_sum) begin
                    $error("conv_sum: expected %0d, got %0d", want.conv_sum,
                        m_data.conv_sum);
                    errors++;
                end
                if (m_data.out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                        m_data.out_of_range);
                    errors++;
                end
            end
        end
    end

    // stop on a long stretch with no handshake at all
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        directed_row_t rows[$];
        c2d_out_t zero_sum, flag_sum;
        c2d_in_t q;
        int per_phase, stop_at, roll;

        zero_sum = '0;
        flag_sum = '0;
        flag_sum.out_of_range = 1'b1;
        reg_raw = '{7'd3, 7'd1, 7'd1, 7'd64, 7'd64, 7'd1};
        refresh_settings();
        foreach (weights[f, r, c]) weights[f][r][c] = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero weights, filter beyond count, extremes of the value
        rows.push_back('{make(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0), 1'b1, zero_sum});
        rows.push_back('{make(OP_COMPUTE, 7, 0, 0, 0, 0, 0, 16'h0), 1'b1, flag_sum});
        rows.push_back('{make(OP_COMPUTE, 1, 0, 0, 0, 5, 5, 16'h0), 1'b1, flag_sum});
        rows.push_back('{make(OP_WEIGHT, 0, 0, 0, 0, 0, 0, 16'h7fff), 1'b0, zero_sum});
        rows.push_back('{make(OP_WEIGHT, 0, 2, 2, 0, 0, 0, 16'h8000), 1'b0, zero_sum});
        rows.push_back('{make(OP_WEIGHT, 0, 1, 1, 0, 0, 0, 16'hffff), 1'b0, zero_sum});
        rows.push_back('{make(OP_WEIGHT, 0, 5, 0, 0, 0, 0, 16'h1234), 1'b0, zero_sum});
        rows.push_back('{make(OP_WEIGHT, 0, 0, 7, 0, 0, 0, 16'h4321), 1'b0, zero_sum});
        rows.push_back('{make(OP_PIXEL, 0, 0, 0, 0, 0, 0, 16'h8000), 1'b0, zero_sum});
        rows.push_back('{make(OP_PIXEL, 0, 0, 0, 0, 0, 1, 16'h7fff), 1'b0, zero_sum});
        rows.push_back('{make(OP_PIXEL, 0, 0, 0, 0, 1, 1, 16'h8000), 1'b0, zero_sum});
        rows.push_back('{make(OP_PIXEL, 0, 0, 0, 3, 63, 63, 16'h0101), 1'b0, zero_sum});
        rows.push_back('{make(OP_NONE, 3, 1, 1, 2, 9, 9, 16'h5555), 1'b0, zero_sum});
        rows.push_back('{make(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0), 1'b0, zero_sum});
        rows.push_back('{make(OP_COMPUTE, 0, 0, 0, 0, 1, 1, 16'h0), 1'b0, zero_sum});
        rows.push_back('{make(OP_COMPUTE, 0, 0, 0, 0, 63, 63, 16'h0), 1'b0, zero_sum});
        rows.push_back('{make(OP_COMPUTE, 0, 0, 0, 0, 0, 63, 16'h0), 1'b0, zero_sum});
        foreach (rows[i]) begin
            if (rows[i].req.operation == OP_COMPUTE)
                compute(rows[i].req, rows[i].typed, rows[i].sum);
            else
                send(rows[i].req);
        end

        // random requests under a run of settings, computes mostly well-formed
        per_phase = ITEMS / $size(PHASES);
        foreach (PHASES[p]) begin
            drain();
            foreach (REG_ORDER[j]) write_reg(REG_ORDER[j], PHASES[p][j]);
            calm = (p % 3 == 1);
            stop_at = requests_sent + per_phase;
            while (requests_sent < stop_at) begin
                q = noise_request();
                roll = $urandom_range(99);
                if (roll < 45) begin
                    q.operation = OP_COMPUTE;
                    if ($urandom_range(9) < 8 && rows_valid > 0 && cols_valid > 0) begin
                        q.filter_index = 3'($urandom_range(f_eff - 1));
                        q.row = 6'($urandom_range(clamp(rows_valid, 1, NH) - 1));
                        q.col = 6'($urandom_range(clamp(cols_valid, 1, NW) - 1));
                    end
                    compute(q);
                end else if (roll < 70) begin
                    q.operation = OP_WEIGHT;
                    if ($urandom_range(9) < 8) begin
                        q.tap_row = 3'($urandom_range(k_eff - 1));
                        q.tap_col = 3'($urandom_range(k_eff - 1));
                    end
                    send(q);
                end else if (roll < 90) begin
                    q.operation = OP_PIXEL;
                    send(q);
                end else begin
                    q.operation = OP_NONE;
                    send(q);
                end
            end
        end

        drain();
        repeat (120) @(posedge aclk);
        $display("covered %0d requests over %0d settings, %0d sums checked (%0d flagged)",
            requests_sent, $size(PHASES) + 1, sums_seen, range_flags);
        if (errors == 0 && pending_sums.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
